>>> hdl/s2a_pkg.sv
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types, codes and the set 1 key map for the scancode-to-ASCII FIFO.
// ----------------------------------------------------------------------------
package s2a_pkg;

    // request kind carried on the input tuser bit
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam int  RELEASE_BIT  = 7;
    localparam logic [6:0] CODE_LSHIFT = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT = 7'h36;

    localparam int CHAR_W = 7;
    localparam int OPQ_DEPTH = 2;

    typedef enum logic {
        OP_PUSH,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [CHAR_W-1:0]   ch;
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_FETCH
    } back_state_t;

    // set 1 key map, plain and shifted; 0 means no character
    function automatic logic [CHAR_W-1:0] key_char(input logic [6:0] code,
                                                   input logic shifted);
        logic [CHAR_W-1:0] ch;
        begin
            case (code)
                7'h02: ch = shifted ? 7'h21 : 7'h31;
                7'h03: ch = shifted ? 7'h40 : 7'h32;
                7'h04: ch = shifted ? 7'h23 : 7'h33;
                7'h05: ch = shifted ? 7'h24 : 7'h34;
                7'h06: ch = shifted ? 7'h25 : 7'h35;
                7'h07: ch = shifted ? 7'h5E : 7'h36;
                7'h08: ch = shifted ? 7'h26 : 7'h37;
                7'h09: ch = shifted ? 7'h2A : 7'h38;
                7'h0A: ch = shifted ? 7'h28 : 7'h39;
                7'h0B: ch = shifted ? 7'h29 : 7'h30;
                7'h0C: ch = shifted ? 7'h5F : 7'h2D;
                7'h0D: ch = shifted ? 7'h2B : 7'h3D;
                7'h0E: ch = 7'h08;
                7'h0F: ch = 7'h09;
                7'h10: ch = shifted ? 7'h51 : 7'h71;
                7'h11: ch = shifted ? 7'h57 : 7'h77;
                7'h12: ch = shifted ? 7'h45 : 7'h65;
                7'h13: ch = shifted ? 7'h52 : 7'h72;
                7'h14: ch = shifted ? 7'h54 : 7'h74;
                7'h15: ch = shifted ? 7'h59 : 7'h79;
                7'h16: ch = shifted ? 7'h55 : 7'h75;
                7'h17: ch = shifted ? 7'h49 : 7'h69;
                7'h18: ch = shifted ? 7'h4F : 7'h6F;
                7'h19: ch = shifted ? 7'h50 : 7'h70;
                7'h1A: ch = shifted ? 7'h7B : 7'h5B;
                7'h1B: ch = shifted ? 7'h7D : 7'h5D;
                7'h1C: ch = 7'h0A;
                7'h1E: ch = shifted ? 7'h41 : 7'h61;
                7'h1F: ch = shifted ? 7'h53 : 7'h73;
                7'h20: ch = shifted ? 7'h44 : 7'h64;
                7'h21: ch = shifted ? 7'h46 : 7'h66;
                7'h22: ch = shifted ? 7'h47 : 7'h67;
                7'h23: ch = shifted ? 7'h48 : 7'h68;
                7'h24: ch = shifted ? 7'h4A : 7'h6A;
                7'h25: ch = shifted ? 7'h4B : 7'h6B;
                7'h26: ch = shifted ? 7'h4C : 7'h6C;
                7'h27: ch = shifted ? 7'h3A : 7'h3B;
                7'h28: ch = shifted ? 7'h22 : 7'h27;
                7'h29: ch = shifted ? 7'h7E : 7'h60;
                7'h2B: ch = shifted ? 7'h7C : 7'h5C;
                7'h2C: ch = shifted ? 7'h5A : 7'h7A;
                7'h2D: ch = shifted ? 7'h58 : 7'h78;
                7'h2E: ch = shifted ? 7'h43 : 7'h63;
                7'h2F: ch = shifted ? 7'h56 : 7'h76;
                7'h30: ch = shifted ? 7'h42 : 7'h62;
                7'h31: ch = shifted ? 7'h4E : 7'h6E;
                7'h32: ch = shifted ? 7'h4D : 7'h6D;
                7'h33: ch = shifted ? 7'h3C : 7'h2C;
                7'h34: ch = shifted ? 7'h3E : 7'h2E;
                7'h35: ch = shifted ? 7'h3F : 7'h2F;
                7'h37: ch = 7'h2A;
                7'h39: ch = 7'h20;
                default: ch = '0;
            endcase
            return ch;
        end
    endfunction

endpackage

>>> hdl/scancode_to_ascii_key_fifo.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_key_fifo
// Set 1 keyboard scancode to ASCII translator with a character ring buffer.
// ----------------------------------------------------------------------------
// Each input transaction is either a scancode byte (s_tuser = 0) or a request
// to read one character (s_tuser = 1). Scancodes update the held-shift flag or
// are mapped to ASCII and pushed into a ring of RING_DEPTH entries that keeps
// at most RING_DEPTH-1 characters; a character that finds the ring full is
// dropped, and a scancode never yields an output transaction. Each read yields
// exactly one output transaction: the oldest character with buffer_empty = 0,
// or 0 with buffer_empty = 1 when nothing is waiting. The front end takes one
// transaction per cycle as long as the two-entry operation queue has room.
// The back end retires one push per cycle except while it fetches a read:
// a read of a non-empty ring goes through BK_FETCH, as the RAM has registered
// read data, and no operation is taken until the character is in the result
// register. The ring needs no clearing after reset; it is ready at once.
// ----------------------------------------------------------------------------
module scancode_to_ascii_key_fifo #(
    parameter int RING_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input: tdata = scan_byte[7:0]; tuser = req_type
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    // output: tdata = ascii_char[6:0], buffer_empty[7]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    // operation handoff from front end to queue and from queue to back end
    logic          fq_valid;
    logic          fq_ready;
    s2a_pkg::op_t  fq_data;
    logic          qb_valid;
    logic          qb_pop;
    s2a_pkg::op_t  qb_data;

    // classify each transaction, track shift, map to ASCII
    s2a_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .op_valid (fq_valid),
        .op_ready (fq_ready),
        .op_data  (fq_data)
    );

    // hold pending operations so front and back stall independently
    s2a_opq u_opq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_pop   (qb_pop),
        .rd_data  (qb_data)
    );

    // ring buffer and result register
    s2a_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (qb_valid),
        .op_pop   (qb_pop),
        .op_data  (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> hdl/s2a_ram.sv
// ----------------------------------------------------------------------------
// s2a_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module s2a_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/s2a_front.sv
// ----------------------------------------------------------------------------
// s2a_front
// Accepts requests, tracks shift, maps scancodes and queues ring operations.
// ----------------------------------------------------------------------------
module s2a_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tuser,
    output logic           op_valid,
    input  logic           op_ready,
    output s2a_pkg::op_t   op_data
);

    logic                        shift_reg;
    logic                        shift_next;
    logic                        accept;
    logic                        is_release;
    logic [6:0]                  code;
    logic                        is_shift_key;
    logic [s2a_pkg::CHAR_W-1:0]  ch;

    assign s_tready     = op_ready;
    assign accept       = s_tvalid && op_ready;
    assign is_release   = s_tdata[s2a_pkg::RELEASE_BIT];
    assign code         = s_tdata[6:0];
    assign is_shift_key = (code == s2a_pkg::CODE_LSHIFT) || (code == s2a_pkg::CODE_RSHIFT);
    assign ch           = s2a_pkg::key_char(code, shift_reg);

    always_comb begin
        shift_next   = shift_reg;
        op_valid     = 1'b0;
        op_data.kind = s2a_pkg::OP_PUSH;
        op_data.ch   = ch;
        if (accept) begin
            if (s_tuser == s2a_pkg::REQ_READ) begin
                op_valid     = 1'b1;
                op_data.kind = s2a_pkg::OP_READ;
            end else if (is_shift_key) begin
                // press sets, release clears
                shift_next = !is_release;
            end else if (!is_release && (ch != '0)) begin
                op_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
        end else begin
            shift_reg <= shift_next;
        end
    end

endmodule

>>> hdl/s2a_opq.sv
// ----------------------------------------------------------------------------
// s2a_opq
// Short register queue of ring operations between front and back.
// ----------------------------------------------------------------------------
module s2a_opq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  s2a_pkg::op_t   wr_data,
    output logic           rd_valid,
    input  logic           rd_pop,
    output s2a_pkg::op_t   rd_data
);

    localparam int PW = $clog2(s2a_pkg::OPQ_DEPTH);
    localparam int CW = $clog2(s2a_pkg::OPQ_DEPTH + 1);

    s2a_pkg::op_t   slot_reg [s2a_pkg::OPQ_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_wr;
    logic           do_rd;

    assign wr_ready = (count_reg != CW'(s2a_pkg::OPQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(s2a_pkg::OPQ_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(s2a_pkg::OPQ_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/s2a_back.sv
// ----------------------------------------------------------------------------
// s2a_back
// Character ring and result register: runs queued push and read operations.
// ----------------------------------------------------------------------------
module s2a_back #(
    parameter int RING_DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           op_valid,
    output logic           op_pop,
    input  s2a_pkg::op_t   op_data,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata
);

    localparam int PW = $clog2(RING_DEPTH);

    s2a_pkg::back_state_t        state_reg;
    s2a_pkg::back_state_t        state_next;
    logic [PW-1:0]               wp_reg;
    logic [PW-1:0]               wp_next;
    logic [PW-1:0]               rp_reg;
    logic [PW-1:0]               rp_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [s2a_pkg::CHAR_W-1:0]  out_char_reg;
    logic [s2a_pkg::CHAR_W-1:0]  out_char_next;
    logic                        out_empty_reg;
    logic                        out_empty_next;
    logic                        out_free;
    logic                        ring_empty;
    logic                        ring_full;
    logic [PW-1:0]               wp_inc;
    logic [PW-1:0]               rp_inc;
    logic                        ram_wr;
    logic                        ram_rd;
    logic [s2a_pkg::CHAR_W-1:0]  ram_q;

    assign wp_inc     = (wp_reg == PW'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc     = (rp_reg == PW'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign ring_empty = (wp_reg == rp_reg);
    assign ring_full  = (wp_inc == rp_reg);
    assign out_free   = !out_valid_reg || m_tready;

    s2a_ram #(
        .WIDTH (s2a_pkg::CHAR_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (wp_reg),
        .wr_data (op_data.ch),
        .rd_en   (ram_rd),
        .rd_addr (rp_reg),
        .rd_data (ram_q)
    );

    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_empty_next = out_empty_reg;
        op_pop         = 1'b0;
        ram_wr         = 1'b0;
        ram_rd         = 1'b0;
        case (state_reg)
            s2a_pkg::BK_IDLE: begin
                if (op_valid) begin
                    if (op_data.kind == s2a_pkg::OP_PUSH) begin
                        op_pop = 1'b1;
                        // drop the character when the ring is full
                        if (!ring_full) begin
                            ram_wr  = 1'b1;
                            wp_next = wp_inc;
                        end
                    end else if (out_free) begin
                        op_pop = 1'b1;
                        if (ring_empty) begin
                            out_valid_next = 1'b1;
                            out_char_next  = '0;
                            out_empty_next = 1'b1;
                        end else begin
                            ram_rd     = 1'b1;
                            rp_next    = rp_inc;
                            state_next = s2a_pkg::BK_FETCH;
                        end
                    end
                end
            end
            s2a_pkg::BK_FETCH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ram_q;
                    out_empty_next = 1'b0;
                    state_next     = s2a_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = s2a_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= s2a_pkg::BK_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg  <= out_char_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_empty_reg, out_char_reg};

endmodule

>>> tb/scancode_to_ascii_key_fifo_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_key_fifo_tb
// Self-checking bench for the set 1 scancode to ASCII key buffer.
// ----------------------------------------------------------------------------
// Drives scancode and read transactions on the input stream and checks every
// read result against a cycle-free model of the shift flag, the key map and
// the character ring. A short table of directed rows comes first, then bursts
// of random traffic that alternate between typing (ring fills and drops) and
// reading (ring drains and reports empty). Both stream sides idle at random,
// the receiver is held off once for a long stretch, and the sender waits for
// all outstanding reads at every phase boundary.
// ----------------------------------------------------------------------------
module scancode_to_ascii_key_fifo_tb;

    localparam int RING_SLOTS   = 16;
    localparam int ITEM_TARGET  = 1300;
    localparam int HOLD_CYCLES  = 120;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [6:0] LAST_MAPPED = 7'h39;

    // one read result, packed the way m_tdata carries it
    typedef struct packed {
        logic       empty;
        logic [6:0] ch;
    } key_result_t;

    typedef struct {
        logic        rq;
        logic [7:0]  code;
        bit          pinned;
        key_result_t res;
    } key_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // scan_byte[7:0]
    logic       s_tuser;   // req_type
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // ascii_char[6:0], buffer_empty[7]

    scancode_to_ascii_key_fifo #(
        .RING_DEPTH(RING_SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Set 1 key map, codes 0x00..0x39; everything above maps to no character.
    logic [7:0] plain_map [0:57] = '{
        8'h00, 8'h00, "1", "2", "3", "4", "5", "6",
        "7", "8", "9", "0", "-", "=", 8'h08, 8'h09,
        "q", "w", "e", "r", "t", "y", "u", "i",
        "o", "p", "[", "]", 8'h0A, 8'h00, "a", "s",
        "d", "f", "g", "h", "j", "k", "l", ";",
        "'", 8'h60, 8'h00, "\\", "z", "x", "c", "v",
        "b", "n", "m", ",", ".", "/", 8'h00, "*",
        8'h00, " "
    };
    logic [7:0] upper_map [0:57] = '{
        8'h00, 8'h00, "!", "@", "#", "$", "%", "^",
        "&", "*", "(", ")", "_", "+", 8'h08, 8'h09,
        "Q", "W", "E", "R", "T", "Y", "U", "I",
        "O", "P", "{", "}", 8'h0A, 8'h00, "A", "S",
        "D", "F", "G", "H", "J", "K", "L", ":",
        "\"", "~", 8'h00, "|", "Z", "X", "C", "V",
        "B", "N", "M", "<", ">", "?", 8'h00, "*",
        8'h00, " "
    };

    // Model state: held shift, the character ring and its two pointers.
    bit         shift_down;
    logic [6:0] char_slots [RING_SLOTS];
    int         put_idx;
    int         take_idx;

    key_result_t pending_chars[$];
    key_row_t    key_rows[$];
    int          mismatches;
    int          counted_items;
    int          src_idle;
    int          snk_idle;
    int          stall_req;
    int          quiet_cycles;

    // Advance the model by one accepted input transaction.
    function automatic void predict_key_item(input logic rq, input logic [7:0] code,
                                             output bit has_out, output key_result_t res);
        logic [6:0] key;
        logic [6:0] ch;
        int         nxt;
        key     = code[6:0];
        has_out = 1'b0;
        res     = '0;
        if (rq == s2a_pkg::REQ_READ) begin
            has_out = 1'b1;
            if (put_idx == take_idx) begin
                res.empty = 1'b1;
            end else begin
                res.ch   = char_slots[take_idx];
                take_idx = (take_idx == RING_SLOTS - 1) ? 0 : take_idx + 1;
            end
        end else if (code[s2a_pkg::RELEASE_BIT]) begin
            // only a shift release matters; prefix bytes and other releases drop out
            if (key == s2a_pkg::CODE_LSHIFT || key == s2a_pkg::CODE_RSHIFT)
                shift_down = 1'b0;
        end else if (key == s2a_pkg::CODE_LSHIFT || key == s2a_pkg::CODE_RSHIFT) begin
            shift_down = 1'b1;
        end else begin
            ch = 7'h00;
            if (key <= LAST_MAPPED)
                ch = shift_down ? upper_map[key][6:0] : plain_map[key][6:0];
            if (ch != 7'h00) begin
                // one slot stays free; a character finding the ring full is lost
                nxt = (put_idx == RING_SLOTS - 1) ? 0 : put_idx + 1;
                if (nxt != take_idx) begin
                    char_slots[put_idx] = ch;
                    put_idx = nxt;
                end
            end
        end
    endfunction

    // Mostly real key traffic: presses in the mapped range, shift press and
    // release, stray releases and a share of fully random bytes.
    function automatic logic [7:0] random_scan_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 8'($urandom_range(0, LAST_MAPPED));
        else if (pick < 65)
            return $urandom_range(1) ? {1'b0, s2a_pkg::CODE_LSHIFT}
                                     : {1'b0, s2a_pkg::CODE_RSHIFT};
        else if (pick < 75)
            return $urandom_range(1) ? {1'b1, s2a_pkg::CODE_LSHIFT}
                                     : {1'b1, s2a_pkg::CODE_RSHIFT};
        else if (pick < 85)
            return {1'b1, 7'($urandom)};
        return 8'($urandom);
    endfunction

    task automatic add_row(input logic rq, input logic [7:0] code, input bit pinned,
                           input key_result_t res);
        key_row_t row;
        row.rq     = rq;
        row.code   = code;
        row.pinned = pinned;
        row.res    = res;
        key_rows.push_back(row);
    endtask

    // Present one transaction from a falling edge, hold it until accepted and
    // return at the falling edge after. tvalid stays high for the next call.
    task automatic send_key_item(input logic rq, input logic [7:0] code, input bit pinned,
                                 input key_result_t pinned_res);
        bit          has_out;
        key_result_t res;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = rq;
        s_tdata  = code;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_key_item(rq, code, has_out, res);
        counted_items++;
        if (has_out)
            pending_chars.push_back(pinned ? pinned_res : res);
        @(negedge aclk);
    endtask

    // Hold off new input until every outstanding read has come back.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_chars.size() != 0)
            @(negedge aclk);
    endtask

    task automatic send_random_burst(input int read_pct, input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < read_pct)
                send_key_item(s2a_pkg::REQ_READ, 8'($urandom), 1'b0, '0);
            else
                send_key_item(s2a_pkg::REQ_SCAN, random_scan_byte(), 1'b0, '0);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random tready, or a long hold whenever the stimulus asks.
    initial begin
        int hold_left;
        int stall_taken;
        hold_left   = 0;
        stall_taken = 0;
        m_tready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (stall_taken != stall_req) begin
                stall_taken = stall_req;
                hold_left   = HOLD_CYCLES - 1;
                m_tready    = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= snk_idle);
            end
        end
    end

    // Compare each accepted result with the oldest expected read.
    initial begin
        key_result_t want;
        key_result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected result ascii_char=%h buffer_empty=%b",
                             $time, got.ch, got.empty);
                    mismatches++;
                end else begin
                    want = pending_chars.pop_front();
                    if (got.ch !== want.ch) begin
                        $display("%0t: ascii_char expected %h, got %h",
                                 $time, want.ch, got.ch);
                        mismatches++;
                    end
                    if (got.empty !== want.empty) begin
                        $display("%0t: buffer_empty expected %b, got %b",
                                 $time, want.empty, got.empty);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no transaction at all.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("scancode_to_ascii_key_fifo: mismatch");
                $finish;
            end
        end
    end

    initial begin
        key_result_t none_waiting;
        int          read_pct;
        none_waiting       = '0;
        none_waiting.empty = 1'b1;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = s2a_pkg::REQ_SCAN;
        mismatches    = 0;
        counted_items = 0;
        stall_req     = 0;
        shift_down    = 1'b0;
        put_idx       = 0;
        take_idx      = 0;
        src_idle      = 19;
        snk_idle      = 53;
        for (int i = 0; i < RING_SLOTS; i++)
            char_slots[i] = '0;

        // Directed rows: empty read after reset, both shifts with their
        // releases, prefix and stray releases, unmapped codes, the extremes of
        // the byte, then read everything back until the ring reports empty.
        add_row(s2a_pkg::REQ_READ, 8'h00, 1'b1, none_waiting);
        add_row(s2a_pkg::REQ_SCAN, 8'h00, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h80, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h02, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, {1'b0, s2a_pkg::CODE_LSHIFT}, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h02, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, {1'b1, s2a_pkg::CODE_LSHIFT}, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, {1'b0, s2a_pkg::CODE_RSHIFT}, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h1E, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'hE0, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h82, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h35, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, {1'b1, s2a_pkg::CODE_RSHIFT}, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h39, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h3A, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h7F, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'hFF, 1'b0, '0);
        add_row(s2a_pkg::REQ_SCAN, 8'h0E, 1'b0, '0);
        for (int i = 0; i < 6; i++)
            add_row(s2a_pkg::REQ_READ, 8'($urandom), 1'b0, '0);
        add_row(s2a_pkg::REQ_READ, 8'hFF, 1'b1, none_waiting);

        // hold reset low, then release it on a falling edge
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        foreach (key_rows[i])
            send_key_item(key_rows[i].rq, key_rows[i].code, key_rows[i].pinned,
                          key_rows[i].res);
        wait_drained();

        // Back-pressure: the receiver stalls for a long stretch while reads
        // and keys keep coming, so the op queue fills and tready drops.
        stall_req++;
        send_random_burst(60, 30);
        wait_drained();

        // Three idling phases: sender light/receiver heavy, swapped, none.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle = 19;
                    snk_idle = 53;
                end
                1: begin
                    src_idle = 53;
                    snk_idle = 19;
                end
                default: begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            while (counted_items < (phase + 1) * ITEM_TARGET / 3) begin
                // typing bursts overrun the ring, reading bursts empty it
                case ($urandom_range(2))
                    0: read_pct = 8;
                    1: read_pct = 70;
                    default: read_pct = 35;
                endcase
                send_random_burst(read_pct, $urandom_range(8, 48));
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("scancode_to_ascii_key_fifo: match");
        end else begin
            $display("scancode_to_ascii_key_fifo: mismatch");
        end
        $finish;
    end

endmodule
